@@ hdl/tgls_pkg.sv @@
// ----------------------------------------------------------------------------
// tgls_pkg
// Shared types and constants for the tap counter and gps led sequencer.
// ----------------------------------------------------------------------------
package tgls_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned M_W    = TIME_W + 2;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam int unsigned SLOW_BLINK_MS_DEF = 800;
    localparam int unsigned FAST_ON_MS_DEF    = 100;
    localparam int unsigned FAST_OFF_MS_DEF   = 100;

    localparam logic [15:0] PRESS_WINDOW_RST = 16'd500;
    localparam logic [15:0] LOCK_CONFIRM_RST = 16'd3000;
    localparam logic [3:0]  OFF_BLINK_RST    = 4'd3;
    localparam logic [3:0]  ON_BLINK_RST     = 4'd2;

    localparam logic [2:0]  TAP_MAX = 3'd7;
    localparam logic [2:0]  TAP_DOUBLE = 3'd2;
    localparam logic [2:0]  TAP_TRIPLE = 3'd3;

    typedef enum logic [1:0] {
        REG_PRESS_WINDOW = 2'd0,
        REG_LOCK_CONFIRM = 2'd1,
        REG_OFF_BLINK    = 2'd2,
        REG_ON_BLINK     = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SEARCH  = 3'd1,
        MODE_LOCK    = 3'd2,
        MODE_PWR_OFF = 3'd3,
        MODE_PWR_ON  = 3'd4
    } led_mode_t;

    typedef enum logic [2:0] {
        LED_HOLD = 3'd0,
        LED_CLR  = 3'd1,
        LED_SET  = 3'd2,
        LED_SLOW = 3'd3,
        LED_FAST = 3'd4
    } led_op_t;

    typedef struct packed {
        logic [15:0] tap_window_ms;
        logic [15:0] lock_confirm_ms;
        logic [3:0]  off_blink_count;
        logic [3:0]  on_blink_count;
    } cfg_t;

    typedef struct packed {
        led_op_t            led_op;
        logic [TIME_W-1:0]  elapsed;
        logic               send_advert;
        logic               gps_set_request;
        logic               gps_set_value;
    } ctl_t;

endpackage

@@ hdl/tgls_cfg.sv @@
// ----------------------------------------------------------------------------
// tgls_cfg
// Configuration register file behind a simple apb-style port.
// ----------------------------------------------------------------------------
module tgls_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgls_pkg::ADDR_W-1:0]   paddr,
    input  logic [tgls_pkg::DATA_W-1:0]   pwdata,
    output logic [tgls_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output tgls_pkg::cfg_t                cfg
);

    tgls_pkg::cfg_t     cfg_reg;
    tgls_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = tgls_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_window_ms   <= tgls_pkg::PRESS_WINDOW_RST;
            cfg_reg.lock_confirm_ms <= tgls_pkg::LOCK_CONFIRM_RST;
            cfg_reg.off_blink_count <= tgls_pkg::OFF_BLINK_RST;
            cfg_reg.on_blink_count  <= tgls_pkg::ON_BLINK_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                tgls_pkg::REG_PRESS_WINDOW: cfg_reg.tap_window_ms   <= pwdata[15:0];
                tgls_pkg::REG_LOCK_CONFIRM: cfg_reg.lock_confirm_ms <= pwdata[15:0];
                tgls_pkg::REG_OFF_BLINK:    cfg_reg.off_blink_count <= pwdata[3:0];
                tgls_pkg::REG_ON_BLINK:     cfg_reg.on_blink_count  <= pwdata[3:0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tgls_pkg::REG_PRESS_WINDOW: prdata = {16'd0, cfg_reg.tap_window_ms};
            tgls_pkg::REG_LOCK_CONFIRM: prdata = {16'd0, cfg_reg.lock_confirm_ms};
            tgls_pkg::REG_OFF_BLINK:    prdata = {28'd0, cfg_reg.off_blink_count};
            tgls_pkg::REG_ON_BLINK:     prdata = {28'd0, cfg_reg.on_blink_count};
            default:                    prdata = '0;
        endcase
    end

endmodule

@@ hdl/tgls_ctrl.sv @@
// ----------------------------------------------------------------------------
// tgls_ctrl
// Input register, tap counting and led mode sequencing for one poll item.
// ----------------------------------------------------------------------------
module tgls_ctrl
#(
    parameter int unsigned FAST_ON_MS  = tgls_pkg::FAST_ON_MS_DEF,
    parameter int unsigned FAST_OFF_MS = tgls_pkg::FAST_OFF_MS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tgls_pkg::TIME_W-1:0]   now_ms,
    input  logic                          button_down,
    input  logic                          gps_on,
    input  logic                          gps_fix,
    input  tgls_pkg::cfg_t                cfg,
    output logic                          ctl_valid,
    input  logic                          ctl_ready,
    output tgls_pkg::ctl_t                ctl
);

    localparam int unsigned FAST_CYC = FAST_ON_MS + FAST_OFF_MS;
    localparam int unsigned CYC_W    = $clog2(FAST_CYC + 1);
    localparam int unsigned LIM_W    = CYC_W + 4;
    localparam int unsigned TW       = tgls_pkg::TIME_W;

    logic                  in_valid_reg;
    logic [TW-1:0]         now_reg;
    logic                  btn_reg;
    logic                  act_reg;
    logic                  vld_reg;

    tgls_pkg::led_mode_t   led_mode_reg;
    tgls_pkg::led_mode_t   led_mode_next;
    tgls_pkg::led_mode_t   mode_tap;
    logic [TW-1:0]         mode_start_reg;
    logic [TW-1:0]         mode_start_next;
    logic [TW-1:0]         start_tap;
    logic                  gps_was_reg;
    logic [2:0]            tap_count_reg;
    logic [2:0]            tap_count_next;
    logic [TW-1:0]         window_end_reg;
    logic [TW-1:0]         window_end_next;
    logic                  btn_was_reg;

    logic                  ctl_valid_reg;
    tgls_pkg::ctl_t        ctl_reg;
    tgls_pkg::ctl_t        ctl_next;

    logic                  ctl_free;
    logic                  adv;
    logic [TW-1:0]         win_delta;
    logic [TW-1:0]         elapsed;
    logic [LIM_W-1:0]      off_lim;
    logic [LIM_W-1:0]      on_lim;
    logic                  advert_bit;
    logic                  set_req_bit;
    logic                  set_val_bit;

    assign ctl_free  = !ctl_valid_reg || ctl_ready;
    assign adv       = in_valid_reg && ctl_free;
    assign s_ready   = !in_valid_reg || ctl_free;
    assign ctl_valid = ctl_valid_reg;
    assign ctl       = ctl_reg;

    assign off_lim = LIM_W'(cfg.off_blink_count) * LIM_W'(FAST_CYC);
    assign on_lim  = LIM_W'(cfg.on_blink_count) * LIM_W'(FAST_CYC);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            now_reg <= now_ms;
            btn_reg <= button_down;
            act_reg <= gps_on;
            vld_reg <= gps_fix;
        end
    end

    // tap window handling
    always_comb
    begin
        tap_count_next  = tap_count_reg;
        window_end_next = window_end_reg;
        mode_tap        = led_mode_reg;
        start_tap       = mode_start_reg;
        advert_bit      = 1'b0;
        set_req_bit     = 1'b0;
        set_val_bit     = 1'b0;
        if (btn_reg && !btn_was_reg)
        begin
            if (tap_count_reg != tgls_pkg::TAP_MAX)
            begin
                tap_count_next = tap_count_reg + 3'd1;
            end
            window_end_next = now_reg + TW'(cfg.tap_window_ms);
        end
        win_delta = now_reg - window_end_next;
        if ((tap_count_next != 3'd0) && (win_delta != '0) && !win_delta[TW-1])
        begin
            advert_bit = (tap_count_next == tgls_pkg::TAP_DOUBLE);
            if (tap_count_next >= tgls_pkg::TAP_TRIPLE)
            begin
                set_req_bit = 1'b1;
                set_val_bit = !act_reg;
                mode_tap  = act_reg ? tgls_pkg::MODE_PWR_OFF : tgls_pkg::MODE_SEARCH;
                start_tap = now_reg;
            end
            tap_count_next = 3'd0;
        end
    end

    // led mode sequencing
    always_comb
    begin
        led_mode_next   = mode_tap;
        mode_start_next = start_tap;
        elapsed         = now_reg - start_tap;
        ctl_next.led_op          = tgls_pkg::LED_HOLD;
        ctl_next.elapsed         = elapsed;
        ctl_next.send_advert     = advert_bit;
        ctl_next.gps_set_request = set_req_bit;
        ctl_next.gps_set_value   = set_val_bit;
        case (mode_tap)
            tgls_pkg::MODE_SEARCH:
            begin
                if (!act_reg)
                begin
                    led_mode_next   = tgls_pkg::MODE_PWR_OFF;
                    mode_start_next = now_reg;
                end
                else if (vld_reg)
                begin
                    led_mode_next   = tgls_pkg::MODE_LOCK;
                    mode_start_next = now_reg;
                    ctl_next.led_op = tgls_pkg::LED_SET;
                end
                else
                begin
                    ctl_next.led_op = tgls_pkg::LED_SLOW;
                end
            end
            tgls_pkg::MODE_LOCK:
            begin
                if (!act_reg)
                begin
                    led_mode_next   = tgls_pkg::MODE_PWR_OFF;
                    mode_start_next = now_reg;
                end
                else if (elapsed >= TW'(cfg.lock_confirm_ms))
                begin
                    led_mode_next   = tgls_pkg::MODE_IDLE;
                    ctl_next.led_op = tgls_pkg::LED_CLR;
                end
            end
            tgls_pkg::MODE_PWR_OFF:
            begin
                if (elapsed >= TW'(off_lim))
                begin
                    led_mode_next   = tgls_pkg::MODE_IDLE;
                    ctl_next.led_op = tgls_pkg::LED_CLR;
                end
                else
                begin
                    ctl_next.led_op = tgls_pkg::LED_FAST;
                end
            end
            tgls_pkg::MODE_PWR_ON:
            begin
                if (!act_reg)
                begin
                    led_mode_next   = tgls_pkg::MODE_PWR_OFF;
                    mode_start_next = now_reg;
                end
                else if (elapsed >= TW'(on_lim))
                begin
                    led_mode_next   = tgls_pkg::MODE_SEARCH;
                    mode_start_next = now_reg;
                end
                else
                begin
                    ctl_next.led_op = tgls_pkg::LED_FAST;
                end
            end
            default:
            begin
                if (act_reg && !vld_reg)
                begin
                    led_mode_next   = tgls_pkg::MODE_PWR_ON;
                    mode_start_next = now_reg;
                end
                else if (gps_was_reg && !act_reg)
                begin
                    led_mode_next   = tgls_pkg::MODE_PWR_OFF;
                    mode_start_next = now_reg;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_mode_reg   <= tgls_pkg::MODE_IDLE;
            mode_start_reg <= '0;
            gps_was_reg    <= 1'b0;
            tap_count_reg  <= 3'd0;
            window_end_reg <= '0;
            btn_was_reg    <= 1'b0;
        end
        else if (adv)
        begin
            led_mode_reg   <= led_mode_next;
            mode_start_reg <= mode_start_next;
            gps_was_reg    <= act_reg;
            tap_count_reg  <= tap_count_next;
            window_end_reg <= window_end_next;
            btn_was_reg    <= btn_reg;
        end
    end

    // control item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_valid_reg <= 1'b0;
        end
        else if (ctl_free)
        begin
            ctl_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_free)
        begin
            ctl_reg <= ctl_next;
        end
    end

    a_tap_step: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (tap_count_reg == $past(tap_count_reg))
             || (tap_count_reg == $past(tap_count_reg) + 3'd1)
             || (tap_count_reg == 3'd0))
        else $error("tap count moved by more than one press");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(led_mode_reg) && $stable(tap_count_reg)
              && $stable(mode_start_reg))
        else $error("sequencer state changed without an item");

endmodule

@@ hdl/tgls_phase.sv @@
// ----------------------------------------------------------------------------
// tgls_phase
// Blink phase pipeline: reciprocal multiply, remainder, led level and result.
// ----------------------------------------------------------------------------
module tgls_phase
#(
    parameter int unsigned SLOW_BLINK_MS = tgls_pkg::SLOW_BLINK_MS_DEF,
    parameter int unsigned FAST_ON_MS    = tgls_pkg::FAST_ON_MS_DEF,
    parameter int unsigned FAST_OFF_MS   = tgls_pkg::FAST_OFF_MS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ctl_valid,
    output logic            ctl_ready,
    input  tgls_pkg::ctl_t  ctl,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            led_on,
    output logic            send_advert,
    output logic            gps_set_request,
    output logic            gps_set_value
);

    localparam int unsigned TW       = tgls_pkg::TIME_W;
    localparam int unsigned MW       = tgls_pkg::M_W;
    localparam int unsigned PW       = TW + MW;
    localparam int unsigned FAST_CYC = FAST_ON_MS + FAST_OFF_MS;
    localparam int unsigned K_SLOW   = TW + $clog2(SLOW_BLINK_MS);
    localparam int unsigned K_FAST   = TW + $clog2(FAST_CYC);
    localparam logic [MW-1:0] M_SLOW =
        MW'(((PW'(1) << K_SLOW) + PW'(SLOW_BLINK_MS) - PW'(1)) / PW'(SLOW_BLINK_MS));
    localparam logic [MW-1:0] M_FAST =
        MW'(((PW'(1) << K_FAST) + PW'(FAST_CYC) - PW'(1)) / PW'(FAST_CYC));
    localparam logic [TW-1:0] D_SLOW   = TW'(SLOW_BLINK_MS);
    localparam logic [TW-1:0] D_FAST   = TW'(FAST_CYC);
    localparam logic [TW-1:0] THR_SLOW = TW'(SLOW_BLINK_MS / 2);
    localparam logic [TW-1:0] THR_FAST = TW'(FAST_ON_MS);

    logic              p_valid_reg;
    tgls_pkg::ctl_t    p_ctl_reg;
    logic [PW-1:0]     p_prod_reg;
    logic [PW-1:0]     p_prod_next;

    logic              qd_valid_reg;
    tgls_pkg::ctl_t    qd_ctl_reg;
    logic [TW-1:0]     qd_reg;
    logic [TW-1:0]     qd_next;
    logic [TW-1:0]     quot;

    logic              o_valid_reg;
    logic [3:0]        o_data_reg;
    logic              led_hold_reg;
    logic              led_next;
    logic [TW-1:0]     rem;
    logic              phase_on;

    logic              out_free;
    logic              qd_free;
    logic              p_free;

    assign out_free  = !o_valid_reg || m_ready;
    assign qd_free   = !qd_valid_reg || out_free;
    assign p_free    = !p_valid_reg || qd_free;
    assign ctl_ready = p_free;

    // stage one: multiply by the reciprocal of the blink period
    always_comb
    begin
        if (ctl.led_op == tgls_pkg::LED_SLOW)
        begin
            p_prod_next = PW'(ctl.elapsed) * PW'(M_SLOW);
        end
        else
        begin
            p_prod_next = PW'(ctl.elapsed) * PW'(M_FAST);
        end
    end

    // stage two: quotient times period
    always_comb
    begin
        if (p_ctl_reg.led_op == tgls_pkg::LED_SLOW)
        begin
            quot    = TW'(p_prod_reg >> K_SLOW);
            qd_next = TW'(quot * D_SLOW);
        end
        else
        begin
            quot    = TW'(p_prod_reg >> K_FAST);
            qd_next = TW'(quot * D_FAST);
        end
    end

    // stage three: remainder compare and led level
    always_comb
    begin
        rem = qd_ctl_reg.elapsed - qd_reg;
        if (qd_ctl_reg.led_op == tgls_pkg::LED_SLOW)
        begin
            phase_on = rem < THR_SLOW;
        end
        else
        begin
            phase_on = rem < THR_FAST;
        end
        case (qd_ctl_reg.led_op)
            tgls_pkg::LED_CLR:  led_next = 1'b0;
            tgls_pkg::LED_SET:  led_next = 1'b1;
            tgls_pkg::LED_SLOW: led_next = phase_on;
            tgls_pkg::LED_FAST: led_next = phase_on;
            default:            led_next = led_hold_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg  <= 1'b0;
            qd_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            led_hold_reg <= 1'b0;
        end
        else
        begin
            if (p_free)
            begin
                p_valid_reg <= ctl_valid;
            end
            if (qd_free)
            begin
                qd_valid_reg <= p_valid_reg;
            end
            if (out_free)
            begin
                o_valid_reg <= qd_valid_reg;
                if (qd_valid_reg)
                begin
                    led_hold_reg <= led_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_free)
        begin
            p_ctl_reg  <= ctl;
            p_prod_reg <= p_prod_next;
        end
        if (qd_free)
        begin
            qd_ctl_reg <= p_ctl_reg;
            qd_reg     <= qd_next;
        end
        if (out_free)
        begin
            o_data_reg <= {qd_ctl_reg.gps_set_value, qd_ctl_reg.gps_set_request,
                           qd_ctl_reg.send_advert, led_next};
        end
    end

    assign m_valid         = o_valid_reg;
    assign led_on          = o_data_reg[0];
    assign send_advert     = o_data_reg[1];
    assign gps_set_request = o_data_reg[2];
    assign gps_set_value   = o_data_reg[3];

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> !(send_advert && gps_set_request))
        else $error("advert and gps request in the same item");

    a_value_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && gps_set_value |-> gps_set_request)
        else $error("gps set value without a request");

    a_led_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_free && qd_valid_reg && (qd_ctl_reg.led_op == tgls_pkg::LED_HOLD)
        |=> led_on == $past(led_hold_reg))
        else $error("held led level lost");

endmodule

@@ hdl/tap_counter_and_gps_led_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// tap_counter_and_gps_led_sequencer_unit
// Counts button taps per press window and drives the gps status led pattern.
// ----------------------------------------------------------------------------
// an item goes through the input, control item and three phase stage registers
// throughput: one item per cycle unless stalled, set by the tap and mode loop
// the blink phase runs through a three-stage reciprocal multiply pipeline
// reset clears tap, mode and led state and loads the register defaults
module tap_counter_and_gps_led_sequencer_unit
#(
    parameter int unsigned SLOW_BLINK_MS = tgls_pkg::SLOW_BLINK_MS_DEF,
    parameter int unsigned FAST_ON_MS    = tgls_pkg::FAST_ON_MS_DEF,
    parameter int unsigned FAST_OFF_MS   = tgls_pkg::FAST_OFF_MS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // now_ms[31:0], button_down[32], gps_on[33], gps_fix[34], zero pad
    input  logic [39:0]                   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // led_on[0], send_advert[1], gps_set_request[2], gps_set_value[3], zero pad
    output logic [7:0]                    m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgls_pkg::ADDR_W-1:0]   paddr,
    input  logic [tgls_pkg::DATA_W-1:0]   pwdata,
    output logic [tgls_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    tgls_pkg::cfg_t  cfg;
    tgls_pkg::ctl_t  ctl;
    logic            ctl_valid;
    logic            ctl_ready;
    logic            led_on;
    logic            send_advert;
    logic            gps_set_request;
    logic            gps_set_value;

    tgls_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgls_ctrl
    #(
        .FAST_ON_MS  (FAST_ON_MS),
        .FAST_OFF_MS (FAST_OFF_MS)
    )
    u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .now_ms      (s_axis_tdata[31:0]),
        .button_down (s_axis_tdata[32]),
        .gps_on      (s_axis_tdata[33]),
        .gps_fix     (s_axis_tdata[34]),
        .cfg         (cfg),
        .ctl_valid   (ctl_valid),
        .ctl_ready   (ctl_ready),
        .ctl         (ctl)
    );

    tgls_phase
    #(
        .SLOW_BLINK_MS (SLOW_BLINK_MS),
        .FAST_ON_MS    (FAST_ON_MS),
        .FAST_OFF_MS   (FAST_OFF_MS)
    )
    u_phase
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl_valid       (ctl_valid),
        .ctl_ready       (ctl_ready),
        .ctl             (ctl),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .led_on          (led_on),
        .send_advert     (send_advert),
        .gps_set_request (gps_set_request),
        .gps_set_value   (gps_set_value)
    );

    assign m_axis_tdata = {4'd0, gps_set_value, gps_set_request, send_advert, led_on};

endmodule
